// ===== hdl/ode_integrator_euler_rk2_rk4_defines.svh =====
// Assertion macros shared by the integrator RTL.
// Each macro expects clk and rst in scope; checks are off while rst is high.
`ifndef ODE_INTEGRATOR_EULER_RK2_RK4_DEFINES_SVH
`define ODE_INTEGRATOR_EULER_RK2_RK4_DEFINES_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ODERK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define ODERK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/oderk_pkg.sv =====
package oderk_pkg;

  localparam int VAL_W      = 32;
  localparam int FRAC_BITS  = 16;
  localparam int H_W        = 16;
  localparam int CNT_W      = 10;
  localparam int MODE_W     = 2;
  localparam int PROD_W     = H_W + 1 + VAL_W;
  localparam int ACC_W      = VAL_W + 3;
  localparam int SAT_W      = PROD_W + 1;
  localparam int DIV_DIGITS = 9;
  localparam int DIV_W      = 4 * DIV_DIGITS;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [H_W-1:0]   STEP_SIZE_RST  = 16'd6554;
  localparam logic [CNT_W-1:0] STEP_COUNT_RST = 10'd10;

  localparam logic [0:0] REG_STEP_SIZE  = 1'b0;
  localparam logic [0:0] REG_STEP_COUNT = 1'b1;

  localparam logic [MODE_W-1:0] MODE_EULER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RK2   = 2'd1;

  localparam logic signed [SAT_W-1:0] Q_MAX = {{(SAT_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
  localparam logic signed [SAT_W-1:0] Q_MIN = {{(SAT_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

  function automatic logic sat_clip(input logic signed [SAT_W-1:0] v);
    return (v > Q_MAX) || (v < Q_MIN);
  endfunction

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > Q_MAX) begin
      r = {1'b0, {(VAL_W-1){1'b1}}};
    end else if (v < Q_MIN) begin
      r = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SAT_W-1:0] sx_val(input logic signed [VAL_W-1:0] v);
    return $signed({{(SAT_W-VAL_W){v[VAL_W-1]}}, v});
  endfunction

  function automatic logic signed [SAT_W-1:0] sx_acc(input logic signed [ACC_W-1:0] v);
    return $signed({{(SAT_W-ACC_W){v[ACC_W-1]}}, v});
  endfunction

  // Quotient digit of x / 6 for x below 96: count the multiples of six not above x.
  function automatic logic [3:0] div6_digit(input logic [6:0] x);
    logic [3:0] d;
    d = '0;
    for (int j = 1; j < 16; j++) begin
      if (x >= 7'(6 * j)) begin
        d = d + 4'd1;
      end
    end
    return d;
  endfunction

endpackage

// ===== hdl/oderk_job_if.sv =====
interface oderk_job_if import oderk_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic signed [VAL_W-1:0] initial_value;

  modport source (output valid, output mode, output initial_value, input ready);
  modport sink   (input valid, input mode, input initial_value, output ready);
endinterface

// ===== hdl/oderk_result_if.sv =====
interface oderk_result_if import oderk_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] final_value;
  logic                    saturated;

  modport source (output valid, output final_value, output saturated, input ready);
  modport sink   (input valid, input final_value, input saturated, output ready);
endinterface

// ===== hdl/oderk_mul.sv =====
module oderk_mul import oderk_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic [H_W-1:0]           h,
  input  logic signed [VAL_W-1:0]  x,
  output logic signed [PROD_W-1:0] prod
);

  // Exact product of the unsigned step and a signed operand, registered.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= $signed({1'b0, h}) * x;
    end
  end

endmodule

// ===== hdl/ode_integrator_euler_rk2_rk4.sv =====
// Fixed-point integrator for dy/dx = 2y. Each job transaction carries a method
// (0 Euler, 1 second-order Runge-Kutta, 2 or 3 classic fourth-order
// Runge-Kutta) and a signed Q16.16 starting value; the block takes step_count
// steps of size step_size (APB register 0 at byte 0, register 1 at byte 4) and
// returns one result transaction with the final value and a sticky flag that
// is set if any slope, product, slope argument or new value was clipped to
// the 32-bit range. All arithmetic runs through one shared 17x32 multiplier
// under a small sequencer, and job.ready is high only while the sequencer is
// idle. Each step runs the multiply, k and argument states once per slope
// evaluation: once for Euler, twice for RK2 and four times for RK4, which then
// divides the weighted slope sum by six, one radix-16 digit at a time, and
// commits the new value in an update state. The result sits in an output
// register, so the next job may start while it waits.
`include "ode_integrator_euler_rk2_rk4_defines.svh"

module ode_integrator_euler_rk2_rk4 import oderk_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  oderk_job_if.sink             job,
  oderk_result_if.source        result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_K    = 7'b0000100,
    S_ARG  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_UPD  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t                   state;
  logic [MODE_W-1:0]        mode_r;
  logic [CNT_W-1:0]         cnt;
  logic [1:0]               stage;
  logic signed [VAL_W-1:0]  y;
  logic signed [VAL_W-1:0]  opnd;
  logic signed [VAL_W-1:0]  kcur;
  logic signed [ACC_W-1:0]  acc;
  logic [DIV_W-1:0]         dsh;
  logic [2:0]               drem;
  logic [3:0]               dcnt;
  logic                     dneg;
  logic                     flag;
  logic [H_W-1:0]           step_size;
  logic [CNT_W-1:0]         step_count;
  logic                     res_valid;
  logic signed [VAL_W-1:0]  res_value;
  logic                     res_sat;

  logic signed [PROD_W-1:0] prod;
  logic signed [SAT_W-1:0]  slope_wide;
  logic signed [VAL_W-1:0]  slope_v;
  logic                     slope_clip;
  logic signed [SAT_W-1:0]  k_wide;
  logic signed [VAL_W-1:0]  k_v;
  logic                     k_clip;
  logic signed [ACC_W-1:0]  k_acc;
  logic signed [SAT_W-1:0]  arg_wide;
  logic signed [VAL_W-1:0]  arg_v;
  logic                     arg_clip;
  logic signed [SAT_W-1:0]  incr_wide;
  logic signed [SAT_W-1:0]  q_wide;
  logic signed [SAT_W-1:0]  upd_wide;
  logic signed [VAL_W-1:0]  ynew;
  logic                     y_clip;
  logic [ACC_W-1:0]         acc_mag;
  logic [6:0]               dx;
  logic [3:0]               dd;
  logic                     is_euler;
  logic                     is_rk2;
  logic                     is_rk4;
  logic                     final_step;
  logic                     cfg_wr;
  logic [0:0]               reg_idx;
  logic                     out_free;

  // Configuration port: zero-wait APB, register picked by the word address.
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (reg_idx)
      REG_STEP_SIZE:  prdata = {{(APB_DATA_W-H_W){1'b0}}, step_size};
      REG_STEP_COUNT: prdata = {{(APB_DATA_W-CNT_W){1'b0}}, step_count};
      default:        prdata = '0;
    endcase
  end

  assign job.ready          = (state == S_IDLE);
  assign result.valid       = res_valid;
  assign result.final_value = res_value;
  assign result.saturated   = res_sat;
  assign out_free           = !res_valid || result.ready;

  // Mode three falls through to fourth-order Runge-Kutta.
  assign is_euler = (mode_r == MODE_EULER);
  assign is_rk2   = (mode_r == MODE_RK2);
  assign is_rk4   = !is_euler && !is_rk2;

  // Shared multiplier: h times the saturated slope 2v of the current argument.
  assign slope_wide = $signed({{(SAT_W-VAL_W-1){opnd[VAL_W-1]}}, opnd, 1'b0});
  assign slope_v    = sat32(slope_wide);
  assign slope_clip = sat_clip(slope_wide);

  oderk_mul u_mul (
    .clk  (clk),
    .en   (state == S_MUL),
    .h    (step_size),
    .x    (slope_v),
    .prod (prod)
  );

  // Floor the product back to Q16.16 and clip it; this is the k value.
  assign k_wide = $signed({{(SAT_W-PROD_W){prod[PROD_W-1]}}, prod}) >>> FRAC_BITS;
  assign k_v    = sat32(k_wide);
  assign k_clip = sat_clip(k_wide);
  assign k_acc  = $signed({{(ACC_W-VAL_W){k_v[VAL_W-1]}}, k_v});

  // Next slope argument: y + k/2 for the midpoints, y + k3 for the last RK4 slope.
  always_comb begin
    if (is_rk4 && stage == 2'd2) begin
      arg_wide = sx_val(y) + sx_val(kcur);
    end else begin
      arg_wide = sx_val(y) + sx_val(kcur >>> 1);
    end
  end
  assign arg_v    = sat32(arg_wide);
  assign arg_clip = sat_clip(arg_wide);

  // Step increment: k1 for Euler, floor((k1 + k2) / 2) for RK2, sum / 6 for RK4.
  assign incr_wide = is_euler ? sx_acc(acc) : sx_acc(acc >>> 1);
  assign q_wide    = dneg ? -$signed({{(SAT_W-DIV_W){1'b0}}, dsh})
                          :  $signed({{(SAT_W-DIV_W){1'b0}}, dsh});
  assign upd_wide  = sx_val(y) + ((state == S_UPD) ? q_wide : incr_wide);
  assign ynew      = sat32(upd_wide);
  assign y_clip    = sat_clip(upd_wide);

  assign final_step = (state == S_UPD) ||
                      ((state == S_ARG) && (is_euler || (is_rk2 && stage == 2'd1)));

  // Divide the magnitude by six one hex digit per cycle; the sign goes back on after.
  assign acc_mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign dx      = {drem, dsh[DIV_W-1 -: 4]};
  assign dd      = div6_digit(dx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_valid  <= 1'b0;
      flag       <= 1'b0;
      step_size  <= STEP_SIZE_RST;
      step_count <= STEP_COUNT_RST;
    end else begin
      if (cfg_wr) begin
        case (reg_idx)
          REG_STEP_SIZE:  step_size  <= pwdata[H_W-1:0];
          REG_STEP_COUNT: step_count <= pwdata[CNT_W-1:0];
          default: ;
        endcase
      end

      // Drop the result once taken; S_DONE reloads the register itself.
      if (result.ready && state != S_DONE) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (job.valid) begin
            mode_r <= job.mode;
            y      <= job.initial_value;
            opnd   <= job.initial_value;
            cnt    <= step_count;
            stage  <= 2'd0;
            flag   <= 1'b0;
            state  <= (step_count == '0) ? S_DONE : S_MUL;
          end
        end
        S_MUL: begin
          if (slope_clip) begin
            flag <= 1'b1;
          end
          state <= S_K;
        end
        S_K: begin
          // Accumulate k1 + 2 k2 + 2 k3 + k4 (RK4) or k1 + k2 (RK2).
          kcur <= k_v;
          if (k_clip) begin
            flag <= 1'b1;
          end
          if (stage == 2'd0) begin
            acc <= k_acc;
          end else if (is_rk4 && stage != 2'd3) begin
            acc <= acc + (k_acc <<< 1);
          end else begin
            acc <= acc + k_acc;
          end
          state <= S_ARG;
        end
        S_ARG: begin
          if (is_rk4 && stage == 2'd3) begin
            dsh   <= {{(DIV_W-ACC_W){1'b0}}, acc_mag};
            dneg  <= acc[ACC_W-1];
            drem  <= '0;
            dcnt  <= '0;
            state <= S_DIV;
          end else if (!final_step) begin
            opnd  <= arg_v;
            stage <= stage + 2'd1;
            if (arg_clip) begin
              flag <= 1'b1;
            end
            state <= S_MUL;
          end
        end
        S_DIV: begin
          drem <= 3'(dx - 7'({dd, 2'b00}) - 7'({dd, 1'b0}));
          dsh  <= {dsh[DIV_W-5:0], dd};
          dcnt <= dcnt + 4'd1;
          if (dcnt == 4'(DIV_DIGITS - 1)) begin
            state <= S_UPD;
          end
        end
        S_UPD: ;
        S_DONE: begin
          // Hold here until the output register is free.
          if (out_free) begin
            res_value <= y;
            res_sat   <= flag;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // Close the step: commit the new y, then advance or finish.
      if (final_step) begin
        y     <= ynew;
        opnd  <= ynew;
        stage <= 2'd0;
        if (y_clip) begin
          flag <= 1'b1;
        end
        if (cnt == CNT_W'(1)) begin
          state <= S_DONE;
        end else begin
          cnt   <= cnt - CNT_W'(1);
          state <= S_MUL;
        end
      end
    end
  end

  `ODERK_ASSERT_NXT(a_accept_leaves_idle, job.valid && job.ready, state != S_IDLE, "accepted job left sequencer idle")
  `ODERK_ASSERT_NXT(a_zero_steps_done, job.valid && job.ready && step_count == '0, state == S_DONE, "zero-step job did not go straight to done")
  `ODERK_ASSERT_IMP(a_euler_one_slope, state == S_MUL && is_euler, stage == 2'd0, "Euler step evaluated more than one slope")
  `ODERK_ASSERT_IMP(a_rk2_two_slopes, state == S_MUL && is_rk2, stage[1] == 1'b0, "RK2 step evaluated more than two slopes")
  `ODERK_ASSERT_IMP(a_div_bound, state == S_DIV, dcnt < 4'(DIV_DIGITS), "divider ran past its last digit")
  `ODERK_ASSERT_NXT(a_done_loads_out, state == S_DONE && out_free, result.valid && result.final_value == $past(y), "result register missed the final value")

endmodule
